/* sv/binom_pkg.sv */
// Types and constants shared by the binomial coefficient block.
// No dependencies.
package binom_pkg;

  localparam int CNT_W  = 6;            // width of n, k and the loop counters
  localparam int COEF_W = 59;           // width of the coefficient
  localparam int DIVD_W = 64;           // width of the running product / dividend
  localparam int PROD_W = COEF_W + CNT_W;
  localparam int BIT_W  = $clog2(DIVD_W);
  localparam int REM_W  = CNT_W;

  localparam logic [BIT_W-1:0]  DIV_LAST = BIT_W'(DIVD_W - 1);
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1);
  localparam logic [COEF_W-1:0] COEF_SAT = {COEF_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } binom_state_t;

endpackage

/* sv/binom_ifs.sv */
// Valid/ready channels for the binomial coefficient block.
// Depends on binom_pkg.
interface binom_in_if import binom_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] total_count;
  logic [CNT_W-1:0] chosen_count;

  modport source (output valid, total_count, chosen_count, input ready);
  modport sink (input valid, total_count, chosen_count, output ready);
endinterface

interface binom_out_if import binom_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;

  modport source (output valid, coefficient, input ready);
  modport sink (input valid, coefficient, output ready);
endinterface

/* sv/binomial_coefficient_top.sv */
// Binomial coefficient C(n,k): a shared multiply step and a one-bit-per-cycle
// restoring divider, run k' = min(k, n-k) times as r = r*(n-i)/(i+1).
// No multiply or divide steps when k = 0, k >= n or n > MAX_N; else k' passes, each a
// multiply step followed by the 64-step divider loop (k' is at most 31).
// Input ready only when idle: no new pair is taken while one is in progress.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid.
module binomial_coefficient_top import binom_pkg::*; #(
  parameter int MAX_N = 62
) (
  input  logic              clk,
  input  logic              rst_n,
  binom_in_if.sink          in_ch,
  binom_out_if.source       out_ch
);

  binom_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   kk_r, kk_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [COEF_W-1:0]  r_r, r_nxt;
  logic [DIVD_W-1:0]  q_r, q_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0]  out_coef_r, out_coef_nxt;

  logic [CNT_W-1:0]   diff_w;
  logic [CNT_W-1:0]   fac_w;
  logic [CNT_W-1:0]   div_w;
  logic [PROD_W-1:0]  prod_w;
  logic [REM_W:0]     trial_w;
  logic               qbit_w;
  logic [REM_W:0]     sub_w;
  logic [DIVD_W-1:0]  q_step_w;
  logic [CNT_W-1:0]   i_inc_w;

  assign diff_w   = in_ch.total_count - in_ch.chosen_count;
  assign fac_w    = n_r - i_r;
  assign i_inc_w  = i_r + CNT_W'(1);
  assign div_w    = i_inc_w;
  assign prod_w   = r_r * fac_w;
  assign trial_w  = {rem_r, q_r[DIVD_W-1]};
  assign qbit_w   = trial_w >= {1'b0, div_w};
  assign sub_w    = trial_w - {1'b0, div_w};
  assign q_step_w = {q_r[DIVD_W-2:0], qbit_w};

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.coefficient = out_coef_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    kk_nxt        = kk_r;
    i_nxt         = i_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    out_coef_nxt  = out_coef_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt = in_ch.total_count;
          i_nxt = '0;
          r_nxt = COEF_ONE;
          kk_nxt = (diff_w < in_ch.chosen_count) ? diff_w : in_ch.chosen_count;
          priority if (in_ch.chosen_count == '0 ||
                       in_ch.chosen_count > in_ch.total_count) begin
            state_nxt = ST_DONE;
          end else if (in_ch.total_count > CNT_W'(MAX_N)) begin
            r_nxt     = COEF_SAT;
            state_nxt = ST_DONE;
          end else if (in_ch.chosen_count == in_ch.total_count) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        q_nxt     = prod_w[DIVD_W-1:0];
        rem_nxt   = '0;
        bit_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        q_nxt   = q_step_w;
        rem_nxt = qbit_w ? sub_w[REM_W-1:0] : trial_w[REM_W-1:0];
        bit_nxt = bit_r + BIT_W'(1);
        if (bit_r == DIV_LAST) begin
          r_nxt     = q_step_w[COEF_W-1:0];
          i_nxt     = i_inc_w;
          state_nxt = (i_inc_w == kk_r) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_coef_nxt  = r_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    kk_r       <= kk_nxt;
    i_r        <= i_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    out_coef_r <= out_coef_nxt;
  end

`ifndef SYNTHESIS
  // each step divides exactly
  a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && bit_r == DIV_LAST) |=> (rem_r == '0))
    else $error("nonzero remainder after division step");

  // quotient fits the coefficient width
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && bit_r == DIV_LAST) |-> (q_step_w[DIVD_W-1:COEF_W] == '0))
    else $error("quotient overflows coefficient");

  // running product fits the dividend
  a_prod_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (prod_w[PROD_W-1:DIVD_W] == '0))
    else $error("product overflows dividend");

  // no result is dropped while one waits
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ch.ready) |=> (state_r == ST_DONE))
    else $error("result lost under stall");
`endif

endmodule
